// File: src/pfp_pkg.sv
`timescale 1ns / 1ps
package pfp_pkg;

    localparam logic [7:0]  HDR_FIRST  = 8'h45;
    localparam logic [7:0]  HDR_SECOND = 8'h53;
    localparam logic [7:0]  FRAME_LEN  = 8'd5;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;

    localparam int unsigned PHASE_W = 3;
    localparam int unsigned COUNT_W = 3;

    localparam logic [PHASE_W-1:0] PH_HDR1    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_HDR2    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LEN     = 3'd2;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd3;
    localparam logic [PHASE_W-1:0] PH_CRC_HI  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_CRC_LO  = 3'd5;

    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_word;

endpackage

// File: src/pfp_if.sv
`timescale 1ns / 1ps
interface pfp_rx_if;
    logic            valid;
    logic            ready;
    pfp_pkg::t_byte  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pfp_pos_if;
    logic            valid;
    logic            ready;
    pfp_pkg::t_word  x_position;
    pfp_pkg::t_word  y_position;

    modport source (output valid, output x_position, output y_position, input ready);
    modport sink   (input valid, input x_position, input y_position, output ready);
endinterface

// File: src/pfp_crc16_byte.sv
`timescale 1ns / 1ps
module pfp_crc16_byte (
    input  pfp_pkg::t_word i_crc,
    input  pfp_pkg::t_byte i_byte,
    output pfp_pkg::t_word o_crc
);

    always_comb begin
        pfp_pkg::t_word c;
        c = i_crc ^ {i_byte, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ pfp_pkg::CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        o_crc = c;
    end

endmodule

// File: src/position_frame_parser_crc16.sv
`timescale 1ns / 1ps
// Output: the output register takes a result word when its CRC low byte advances and the CRC matches.
// Throughput: one byte per cycle; the input register refills while the output
// register holds a result, stalling only when the output register is full.
// Reset: synchronous, active low; clears the hunt to the first header byte,
// the CRC to 0xFFFF and both valid flags. Stored payload bytes are not reset.
module position_frame_parser_crc16 (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pfp_rx_if.sink        i_rx,
    pfp_pos_if.source     o_pos
);

    logic                               r_in_valid;
    pfp_pkg::t_byte                     r_in_byte;
    logic [pfp_pkg::PHASE_W-1:0]        r_phase, n_phase;
    logic [pfp_pkg::COUNT_W-1:0]        r_count, n_count;
    pfp_pkg::t_word                     r_crc, n_crc;
    pfp_pkg::t_byte                     r_crc_hi, n_crc_hi;
    pfp_pkg::t_byte                     r_store [5];
    logic                               r_out_valid, n_out_valid;
    pfp_pkg::t_word                     r_x, r_y;

    logic                               advance;
    logic                               emit;
    pfp_pkg::t_word                     crc_base;
    pfp_pkg::t_word                     crc_next;
    logic [pfp_pkg::COUNT_W:0]          count_inc;

    assign advance    = r_in_valid && (!r_out_valid || o_pos.ready);
    assign i_rx.ready = !r_in_valid || advance;

    assign o_pos.valid      = r_out_valid;
    assign o_pos.x_position = r_x;
    assign o_pos.y_position = r_y;

    assign crc_base  = (r_phase == pfp_pkg::PH_LEN) ? pfp_pkg::CRC_INIT : r_crc;
    assign count_inc = {1'b0, r_count} + 1'b1;

    pfp_crc16_byte u_crc (
        .i_crc  (crc_base),
        .i_byte (r_in_byte),
        .o_crc  (crc_next)
    );

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_crc    = r_crc;
        n_crc_hi = r_crc_hi;
        emit     = 1'b0;
        case (r_phase)
            pfp_pkg::PH_HDR2: begin
                if (r_in_byte == pfp_pkg::HDR_SECOND) begin
                    n_phase = pfp_pkg::PH_LEN;
                end else if (r_in_byte != pfp_pkg::HDR_FIRST) begin
                    n_phase = pfp_pkg::PH_HDR1;
                end
            end
            pfp_pkg::PH_LEN: begin
                if (r_in_byte == pfp_pkg::FRAME_LEN) begin
                    n_count = '0;
                    n_crc   = crc_next;
                    n_phase = pfp_pkg::PH_PAYLOAD;
                end else if (r_in_byte == pfp_pkg::HDR_FIRST) begin
                    n_phase = pfp_pkg::PH_HDR2;
                end else begin
                    n_phase = pfp_pkg::PH_HDR1;
                end
            end
            pfp_pkg::PH_PAYLOAD: begin
                n_crc   = crc_next;
                n_count = count_inc[pfp_pkg::COUNT_W-1:0];
                if (count_inc >= {1'b0, pfp_pkg::FRAME_LEN[pfp_pkg::COUNT_W-1:0]}) begin
                    n_phase = pfp_pkg::PH_CRC_HI;
                end
            end
            pfp_pkg::PH_CRC_HI: begin
                n_crc_hi = r_in_byte;
                n_phase  = pfp_pkg::PH_CRC_LO;
            end
            pfp_pkg::PH_CRC_LO: begin
                emit    = ({r_crc_hi, r_in_byte} == r_crc);
                n_phase = (r_in_byte == pfp_pkg::HDR_FIRST) ? pfp_pkg::PH_HDR2
                                                            : pfp_pkg::PH_HDR1;
            end
            default: begin
                n_phase = (r_in_byte == pfp_pkg::HDR_FIRST) ? pfp_pkg::PH_HDR2
                                                            : pfp_pkg::PH_HDR1;
            end
        endcase
        if (advance) begin
            n_out_valid = emit;
        end else begin
            n_out_valid = r_out_valid && !o_pos.ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_phase     <= pfp_pkg::PH_HDR1;
            r_count     <= '0;
            r_crc       <= pfp_pkg::CRC_INIT;
            r_crc_hi    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_rx.ready) begin
                r_in_valid <= i_rx.valid;
            end
            if (advance) begin
                r_phase  <= n_phase;
                r_count  <= n_count;
                r_crc    <= n_crc;
                r_crc_hi <= n_crc_hi;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
        if (advance && r_phase == pfp_pkg::PH_PAYLOAD && r_count < 3'd5) begin
            r_store[r_count] <= r_in_byte;
        end
        if (advance && emit) begin
            r_x <= {r_store[1], r_store[2]};
            r_y <= {r_store[3], r_store[4]};
        end
    end

    a_emit_after_crc_lo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(advance && r_phase == pfp_pkg::PH_CRC_LO))
        else $error("result raised without a CRC low byte");

    a_count_full_at_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == pfp_pkg::PH_CRC_HI || r_phase == pfp_pkg::PH_CRC_LO)
        |-> r_count == pfp_pkg::FRAME_LEN[pfp_pkg::COUNT_W-1:0])
        else $error("CRC phase reached with short payload");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rx.ready |-> (r_in_valid && r_out_valid && !o_pos.ready))
        else $error("input stalled without a full output register");

    a_state_frozen_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(advance) |-> $stable(r_phase) && $stable(r_crc))
        else $error("parser state moved without a word");

endmodule
